### rtl/thtg_pkg.sv
// ----------------------------------------------------------------------------
// thtg_pkg
// Shared widths, constants and the quarter-wave sine table of the tone
// generator.
// ----------------------------------------------------------------------------
package thtg_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 32;

  localparam int INDEX_W  = 32;
  localparam int STEP_W   = 32;
  localparam int SAMPLE_W = 16;

  // quarter table geometry
  localparam int QUAD_BITS = SINE_TABLE_BITS - 2;
  localparam int QSTEPS    = 1 << QUAD_BITS;
  localparam int QSINE_W   = 15;
  localparam int SINE_W    = 16;

  localparam logic [STEP_W-1:0] PHASE_KEEP = {STEP_W{1'b1}} << (STEP_W - PHASE_BITS);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int          ONE_Q14     = 16384;

  // mix: t = 6*s1 + 3*s2 + 2*s3, biased so that the divide sees a positive value
  localparam int MIX_W       = 20;
  localparam int MIX_U_W     = 19;
  localparam int MIX_BIAS    = 3 + 6 * 32768;
  // divide by 6 as multiply by ceil(2^22 / 6), exact for values below 2^21
  localparam int DIV6_SHIFT  = 22;
  localparam int DIV6_W      = 20;
  localparam logic [DIV6_W-1:0] DIV6_RECIP = DIV6_W'(((1 << DIV6_SHIFT) + 5) / 6);
  localparam int QUOT_W      = 17;
  localparam int PROD6_W     = MIX_U_W + DIV6_W;

  typedef logic [QSINE_W-1:0] qsine_tab_t [QSTEPS];

  // fixed taylor series of sin at k/QSTEPS of a quarter turn, rounded to q14
  function automatic logic [QSINE_W-1:0] qsine_val(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x    = (64'(k) * HALF_PI_Q30) >> QUAD_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    r = ($unsigned(sum) + 64'd32768) >> 16;
    if (r > 64'(ONE_Q14)) begin
      r = 64'(ONE_Q14);
    end
    return r[QSINE_W-1:0];
  endfunction

  function automatic qsine_tab_t build_qsine();
    qsine_tab_t tab;
    for (int k = 0; k < QSTEPS; k++) begin
      tab[k] = qsine_val(k);
    end
    return tab;
  endfunction

  // entries 0 .. QSTEPS-1, and the quarter-turn point on its own
  localparam qsine_tab_t          QSINE     = build_qsine();
  localparam logic [QSINE_W-1:0]  QSINE_TOP = qsine_val(QSTEPS);

endpackage

### rtl/thtg_if.sv
// ----------------------------------------------------------------------------
// thtg_if
// Valid/ready channels of the tone generator: sample indexes in, samples out.
// ----------------------------------------------------------------------------
interface thtg_index_if
  import thtg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink   (input valid, input sample_index, output ready);
endinterface

interface thtg_sample_if
  import thtg_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### rtl/thtg_sine_lookup.sv
// ----------------------------------------------------------------------------
// thtg_sine_lookup
// Full-wave sine from the quarter-wave table: quadrant folding and sign.
// ----------------------------------------------------------------------------
module thtg_sine_lookup
  import thtg_pkg::*;
(
  input  logic [SINE_TABLE_BITS-1:0] idx,
  output logic signed [SINE_W-1:0]   sine
);

  logic [1:0]           quad;
  logic [QUAD_BITS-1:0] k;
  logic [QUAD_BITS-1:0] k_rev;
  logic [QSINE_W-1:0]   mag;

  always_comb begin
    quad  = idx[SINE_TABLE_BITS-1 -: 2];
    k     = idx[QUAD_BITS-1:0];
    k_rev = '0 - k;
    if (quad[0]) begin
      // mirrored quadrant, k of zero lands on the quarter-turn point
      mag = (k == '0) ? QSINE_TOP : QSINE[k_rev];
    end else begin
      mag = QSINE[k];
    end
    if (quad[1]) begin
      sine = -$signed({1'b0, mag});
    end else begin
      sine = $signed({1'b0, mag});
    end
  end

endmodule

### rtl/three_harmonic_tone_generator.sv
// ----------------------------------------------------------------------------
// three_harmonic_tone_generator
// Sample index in, sin(p) + sin(2p)/2 + sin(3p)/3 out as signed q2.14.
// ----------------------------------------------------------------------------
// usage:
//   index_ch carries one sample index per word, tone_ch returns one sample per
//   word, in order. phase_step (q0.32, frequency / sample rate) is loaded
//   via cfg_wr_en / cfg_wr_data, by the user while the block is idle; the block does not enforce it.
//   five register stages: phase multiply, harmonic phases, table lookup,
//   harmonic mix, divide by 6 and saturate. an accepted word passes through
//   these stages in that order and is shown on tone_ch from the last one.
//   throughput is one word per cycle while tone_ch does not stall; every
//   stage, including the 32x32 phase multiplier and the divide-by-6
//   multiplier, takes a new word each cycle when nothing stalls.
//   reset clears all stage valid bits and sets phase_step to 0.
//   when tone_ch stalls, the output word holds and each stage keeps its word
//   until the one after it frees up; empty stages in front still fill, so
//   index_ch is refused only once all five stages are full.
// ----------------------------------------------------------------------------
module three_harmonic_tone_generator
  import thtg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [STEP_W-1:0]   cfg_wr_data,
  thtg_index_if.sink          index_ch,
  thtg_sample_if.source       tone_ch
);

  logic [STEP_W-1:0] phase_step;

  // stage valid bits and per-stage ready
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [STEP_W-1:0]               prod;
  logic [SINE_TABLE_BITS-1:0]      hidx [3];
  logic signed [SINE_W-1:0]        sine [3];
  logic [MIX_U_W-1:0]              mix;
  logic signed [SAMPLE_W-1:0]      sample;

  logic [STEP_W-1:0]               ph1;
  logic [STEP_W-1:0]               ph2;
  logic [STEP_W-1:0]               ph3;
  logic signed [SINE_W-1:0]        sine_lk [3];
  logic signed [MIX_W-1:0]         mix_s;
  logic [PROD6_W-1:0]              prod6;
  logic [QUOT_W-1:0]               quot;
  logic signed [QUOT_W:0]          centered;
  logic signed [SAMPLE_W-1:0]      sample_next;

  assign rdy5 = !v5 || tone_ch.ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign index_ch.ready = rdy1;
  assign tone_ch.valid  = v5;
  assign tone_ch.sample = sample;

  always_comb begin
    ph1 = prod & PHASE_KEEP;
    ph2 = ph1 << 1;
    ph3 = ph1 + ph2;
  end

  for (genvar h = 0; h < 3; h++) begin : g_lookup
    thtg_sine_lookup u_lookup (
      .idx  (hidx[h]),
      .sine (sine_lk[h])
    );
  end

  always_comb begin
    mix_s = MIX_W'(sine[0]) * 20'sd6 + MIX_W'(sine[1]) * 20'sd3
          + MIX_W'(sine[2]) * 20'sd2 + MIX_W'(MIX_BIAS);
    prod6 = PROD6_W'(mix) * PROD6_W'(DIV6_RECIP);
    quot  = QUOT_W'(prod6 >> DIV6_SHIFT);
    centered = $signed({1'b0, quot}) - 18'sd32768;
    if (centered > 18'sd32767) begin
      sample_next = 16'sh7fff;
    end else if (centered < -18'sd32768) begin
      sample_next = -16'sh8000;
    end else begin
      sample_next = SAMPLE_W'(centered);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        phase_step <= cfg_wr_data;
      end
      if (rdy1) v1 <= index_ch.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      // only the low word of the product matters, the phase wraps
      prod <= STEP_W'(index_ch.sample_index * phase_step);
    end
    if (rdy2) begin
      hidx[0] <= ph1[STEP_W-1 -: SINE_TABLE_BITS];
      hidx[1] <= ph2[STEP_W-1 -: SINE_TABLE_BITS];
      hidx[2] <= ph3[STEP_W-1 -: SINE_TABLE_BITS];
    end
    if (rdy3) begin
      sine <= sine_lk;
    end
    if (rdy4) begin
      mix <= MIX_U_W'(mix_s);
    end
    if (rdy5) begin
      sample <= sample_next;
    end
  end

  a_accept_fills_first: assert property (@(posedge clk) disable iff (rst)
    index_ch.valid && index_ch.ready |=> v1)
    else $error("accepted word did not reach the first stage");

  a_stall_holds_mix: assert property (@(posedge clk) disable iff (rst)
    v4 && v5 && !tone_ch.ready |=> v4 && $stable(mix))
    else $error("mix stage lost its word under a stall");

  a_sine_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (sine[0] <= 16'sd16384) && (sine[0] >= -16'sd16384)
        && (sine[2] <= 16'sd16384) && (sine[2] >= -16'sd16384))
    else $error("looked-up sine beyond one");

  a_no_clip: assert property (@(posedge clk) disable iff (rst)
    v5 |-> (sample != 16'sh7fff) && (sample != -16'sh8000))
    else $error("harmonic sum reached the saturation limit");

endmodule
